@@ rtl/egcd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Extended GCD package
// Shared controller states and the command and status bundles that join the
// sequencer to the arithmetic datapath.
// ----------------------------------------------------------------------------
package egcd_pkg;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_UPDATE
	} egcd_state_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic load;       // take a new operand pair
		logic start_div;  // prime the divider for one quotient step
		logic div_step;   // one restoring division bit
		logic update;     // rotate remainder and coefficient pairs
		logic capture;    // copy the finished result to the output registers
	} egcd_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic r1_zero;    // current divisor is zero, algorithm is finished
	} egcd_sts_t;

endpackage
`default_nettype wire

@@ rtl/egcd_op_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Operand channel
// Valid/ready channel that carries one operand pair per transfer.
// ----------------------------------------------------------------------------
interface egcd_op_if #(
	parameter int DATA_WIDTH = 32
) ();
	logic                  valid;
	logic                  ready;
	logic [DATA_WIDTH-2:0] operand_a;
	logic [DATA_WIDTH-2:0] operand_b;

	modport source (output valid, output operand_a, output operand_b, input ready);
	modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface
`default_nettype wire

@@ rtl/egcd_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries the gcd and both Bezout coefficients.
// ----------------------------------------------------------------------------
interface egcd_res_if #(
	parameter int DATA_WIDTH = 32
) ();
	logic                         valid;
	logic                         ready;
	logic [DATA_WIDTH-2:0]        divisor_out;
	logic signed [DATA_WIDTH-1:0] coef_a;
	logic signed [DATA_WIDTH-1:0] coef_b;

	modport source (output valid, output divisor_out, output coef_a, output coef_b,
		input ready);
	modport sink   (input valid, input divisor_out, input coef_a, input coef_b,
		output ready);
endinterface
`default_nettype wire

@@ rtl/egcd_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Extended GCD datapath
// Remainder and coefficient pairs, a radix-2 restoring divider and two
// shift-and-add accumulators that form q*s1 and q*t1 as quotient bits appear.
// ----------------------------------------------------------------------------
module egcd_dp #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire egcd_pkg::egcd_cmd_t          cmd,
	output egcd_pkg::egcd_sts_t               sts,
	input  wire logic [DATA_WIDTH-2:0]        operand_a,
	input  wire logic [DATA_WIDTH-2:0]        operand_b,
	output logic [DATA_WIDTH-2:0]             divisor_out,
	output logic signed [DATA_WIDTH-1:0]      coef_a,
	output logic signed [DATA_WIDTH-1:0]      coef_b
);
	localparam int OW = DATA_WIDTH - 1;
	localparam int CW = DATA_WIDTH;

	logic [OW-1:0] r0_q, r1_q;
	logic [CW-1:0] s0_q, s1_q, t0_q, t1_q;
	logic [OW-1:0] rem_q, dvd_q;
	logic [CW-1:0] acc_s_q, acc_t_q;
	logic [OW-1:0] gcd_q;
	logic [CW-1:0] ca_q, cb_q;

	logic [OW:0]   trial;
	logic          q_bit;
	logic [OW-1:0] rem_d;

	// One restoring division step: bring in the next dividend bit and subtract
	// the divisor when it fits.
	always_comb begin
		trial = {rem_q, dvd_q[OW-1]};
		q_bit = (trial >= {1'b0, r1_q});
		if (q_bit) begin
			rem_d = OW'(trial - {1'b0, r1_q});
		end else begin
			rem_d = trial[OW-1:0];
		end
	end

	// Working registers; no reset needed on payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r0_q <= operand_a;
			r1_q <= operand_b;
			s0_q <= CW'(1);
			s1_q <= '0;
			t0_q <= '0;
			t1_q <= CW'(1);
		end else if (cmd.update) begin
			r0_q <= r1_q;
			r1_q <= rem_q;
			s0_q <= s1_q;
			s1_q <= s0_q - acc_s_q;
			t0_q <= t1_q;
			t1_q <= t0_q - acc_t_q;
		end

		if (cmd.start_div) begin
			rem_q   <= '0;
			dvd_q   <= r0_q;
			acc_s_q <= '0;
			acc_t_q <= '0;
		end else if (cmd.div_step) begin
			rem_q   <= rem_d;
			dvd_q   <= {dvd_q[OW-2:0], 1'b0};
			acc_s_q <= {acc_s_q[CW-2:0], 1'b0} + (q_bit ? s1_q : '0);
			acc_t_q <= {acc_t_q[CW-2:0], 1'b0} + (q_bit ? t1_q : '0);
		end

		if (cmd.capture) begin
			gcd_q <= r0_q;
			ca_q  <= s0_q;
			cb_q  <= t0_q;
		end
	end

	// Status and result outputs.
	assign sts.r1_zero = (r1_q == '0);
	assign divisor_out = gcd_q;
	assign coef_a      = $signed(ca_q);
	assign coef_b      = $signed(cb_q);

endmodule
`default_nettype wire

@@ rtl/egcd_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Extended GCD sequencer
// Steps the datapath through Euclid iterations and owns both handshakes.
// ----------------------------------------------------------------------------
module egcd_ctrl #(
	parameter int OP_WIDTH = 31
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output egcd_pkg::egcd_cmd_t      cmd,
	input  wire egcd_pkg::egcd_sts_t sts
);
	localparam int CNT_W = $clog2(OP_WIDTH);

	egcd_pkg::egcd_state_t state_q, state_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic                  out_valid_q, out_valid_d;
	logic                  out_free;

	// State, bit counter and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= egcd_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		in_ready    = 1'b0;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		unique case (state_q)
			egcd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = egcd_pkg::ST_CHECK;
				end
			end
			egcd_pkg::ST_CHECK: begin
				if (sts.r1_zero) begin
					// Finished: hand the result over once the output register frees.
					if (out_free) begin
						cmd.capture = 1'b1;
						out_valid_d = 1'b1;
						state_d     = egcd_pkg::ST_IDLE;
					end
				end else begin
					cmd.start_div = 1'b1;
					cnt_d         = CNT_W'(OP_WIDTH - 1);
					state_d       = egcd_pkg::ST_DIV;
				end
			end
			egcd_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = egcd_pkg::ST_UPDATE;
				end else begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end
			egcd_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = egcd_pkg::ST_CHECK;
			end
			default: begin
				state_d = egcd_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ rtl/extended_gcd.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Extended GCD
// Computes gcd(a, b) and Bezout coefficients s, t with s*a + t*b = gcd.
// ----------------------------------------------------------------------------
// Usage: operand pairs arrive on the operands channel and one result per pair
// leaves on the results channel; both are valid/ready, a transfer happens
// when valid and ready are high at a rising clock edge.
// Operands are DATA_WIDTH-1 bits unsigned, coefficients DATA_WIDTH bits
// two's complement. Zero operands are handled: with b zero the result is
// gcd = a, s = 1, t = 0.
// Timing: one pair is processed at a time. Each Euclid iteration passes
// through a check state, a run of radix-2 divider steps (one per quotient
// bit) that also accumulate q*s and q*t, and an update state. A result
// becomes valid after k such iterations and a final check; k is at most
// about 46 at the default width.
// A registered output decouples the sides: while a result waits for the
// receiver, the next pair is taken and computed, and the block stalls only
// when that next result is ready before the previous one has left.
// Reset clears the sequencer and drops any result not yet transferred.
// ----------------------------------------------------------------------------
module extended_gcd #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	egcd_op_if.sink    operands,
	egcd_res_if.source results
);
	egcd_pkg::egcd_cmd_t cmd;
	egcd_pkg::egcd_sts_t sts;

	// Sequencer.
	egcd_ctrl #(
		.OP_WIDTH(DATA_WIDTH - 1)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (operands.valid),
		.in_ready (operands.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Arithmetic datapath.
	egcd_dp #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.sts        (sts),
		.operand_a  (operands.operand_a),
		.operand_b  (operands.operand_b),
		.divisor_out(results.divisor_out),
		.coef_a     (results.coef_a),
		.coef_b     (results.coef_b)
	);

endmodule
`default_nettype wire
